FILE: hdl/pced_pkg.sv
// ----------------------------------------------------------------------------
// pced_pkg
// Shared types and constants for the point crop / ego / decimate core.
// ----------------------------------------------------------------------------
package pced_pkg;

    localparam int COORD_BITS = 16;
    localparam int INDEX_BITS = 20;
    localparam int NEXT_BITS  = INDEX_BITS + 1;
    localparam int FRAC_BITS  = 16;
    localparam int BOX_BITS   = 3 * COORD_BITS;
    localparam int INT_BITS   = 8;
    localparam int TIME_BITS  = 32;

    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 6;
    localparam int CFG_SEL_LSB   = 3;
    localparam int CFG_SEL_BITS  = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_SEL_BITS-1:0] {
        REG_CROP_LOW    = 3'd0,
        REG_CROP_HIGH   = 3'd1,
        REG_EGO_LOW     = 3'd2,
        REG_EGO_HIGH    = 3'd3,
        REG_STRIDE      = 3'd4,
        REG_STRIDE_FRAC = 3'd5
    } reg_sel_t;

    typedef struct packed {
        logic [BOX_BITS-1:0]   crop_low;
        logic [BOX_BITS-1:0]   crop_high;
        logic [BOX_BITS-1:0]   ego_low;
        logic [BOX_BITS-1:0]   ego_high;
        logic [INDEX_BITS-1:0] stride;
        logic [FRAC_BITS-1:0]  stride_frac;
    } cfg_t;

    // stride resets to 1, everything else to 0
    localparam cfg_t CFG_RESET = '{stride: INDEX_BITS'(1), default: '0};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [INT_BITS-1:0]          intensity;
        logic [INT_BITS-1:0]          ring;
        logic [TIME_BITS-1:0]         ptime;
    } point_t;

endpackage

FILE: hdl/point_crop_ego_decimate_core.sv
// ----------------------------------------------------------------------------
// point_crop_ego_decimate_core
// Crop-box / ego-box filter with stride decimation on a lidar point stream.
//
//   channel   handshake              payload
//   points    push / full            pos_x pos_y pos_z intensity ring pt_stamp cloud_last
//   results   empty / pop            out_x out_y out_z out_intensity out_ring out_time
//   config    psel penable pwrite    paddr (8-byte regs) pwdata prdata
//
// One point per cycle while full is low; classification and index update finish
// in the accepting cycle, kept points land in a 4-entry result queue.
// A kept point shows on the result ports the cycle after its push if the queue was empty.
// full rises only while the result queue holds 4 points.
// Reset is asynchronous; stride resets to 1, all other state but queue storage to 0.
// ----------------------------------------------------------------------------
module point_crop_ego_decimate_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pced_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [pced_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [pced_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic signed [pced_pkg::COORD_BITS-1:0] pos_x,
    input  logic signed [pced_pkg::COORD_BITS-1:0] pos_y,
    input  logic signed [pced_pkg::COORD_BITS-1:0] pos_z,
    input  logic [pced_pkg::INT_BITS-1:0]       intensity,
    input  logic [pced_pkg::INT_BITS-1:0]       ring,
    input  logic [pced_pkg::TIME_BITS-1:0]      pt_stamp,
    input  logic                                cloud_last,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [pced_pkg::COORD_BITS-1:0] out_x,
    output logic signed [pced_pkg::COORD_BITS-1:0] out_y,
    output logic signed [pced_pkg::COORD_BITS-1:0] out_z,
    output logic [pced_pkg::INT_BITS-1:0]       out_intensity,
    output logic [pced_pkg::INT_BITS-1:0]       out_ring,
    output logic [pced_pkg::TIME_BITS-1:0]      out_time
);

    pced_pkg::cfg_t   cfg;
    pced_pkg::point_t in_point;
    pced_pkg::point_t head;
    logic             q_full;
    logic             q_wr;
    logic             accept;

    assign in_point.x         = pos_x;
    assign in_point.y         = pos_y;
    assign in_point.z         = pos_z;
    assign in_point.intensity = intensity;
    assign in_point.ring      = ring;
    assign in_point.ptime     = pt_stamp;

    assign full   = q_full;
    assign accept = push && !q_full;

    pced_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pced_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (accept),
        .in_last  (cloud_last),
        .in_point (in_point),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    pced_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_point (in_point),
        .rd       (pop),
        .full     (q_full),
        .empty    (empty),
        .head     (head)
    );

    assign out_x         = head.x;
    assign out_y         = head.y;
    assign out_z         = head.z;
    assign out_intensity = head.intensity;
    assign out_ring      = head.ring;
    assign out_time      = head.ptime;

endmodule

FILE: hdl/pced_cfg.sv
// ----------------------------------------------------------------------------
// pced_cfg
// APB-style register file holding crop/ego boxes and decimation stride.
// ----------------------------------------------------------------------------
module pced_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pced_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [pced_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [pced_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output pced_pkg::cfg_t                       cfg
);

    pced_pkg::cfg_t   cfg_reg;
    pced_pkg::cfg_t   cfg_next;
    logic             wr_en;
    pced_pkg::reg_sel_t sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = pced_pkg::reg_sel_t'(
        paddr[pced_pkg::CFG_SEL_LSB +: pced_pkg::CFG_SEL_BITS]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                pced_pkg::REG_CROP_LOW:
                    cfg_next.crop_low = pwdata[pced_pkg::BOX_BITS-1:0];
                pced_pkg::REG_CROP_HIGH:
                    cfg_next.crop_high = pwdata[pced_pkg::BOX_BITS-1:0];
                pced_pkg::REG_EGO_LOW:
                    cfg_next.ego_low = pwdata[pced_pkg::BOX_BITS-1:0];
                pced_pkg::REG_EGO_HIGH:
                    cfg_next.ego_high = pwdata[pced_pkg::BOX_BITS-1:0];
                pced_pkg::REG_STRIDE:
                    cfg_next.stride = pwdata[pced_pkg::INDEX_BITS-1:0];
                pced_pkg::REG_STRIDE_FRAC:
                    cfg_next.stride_frac = pwdata[pced_pkg::FRAC_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            pced_pkg::REG_CROP_LOW:
                prdata = pced_pkg::CFG_DATA_BITS'(cfg_reg.crop_low);
            pced_pkg::REG_CROP_HIGH:
                prdata = pced_pkg::CFG_DATA_BITS'(cfg_reg.crop_high);
            pced_pkg::REG_EGO_LOW:
                prdata = pced_pkg::CFG_DATA_BITS'(cfg_reg.ego_low);
            pced_pkg::REG_EGO_HIGH:
                prdata = pced_pkg::CFG_DATA_BITS'(cfg_reg.ego_high);
            pced_pkg::REG_STRIDE:
                prdata = pced_pkg::CFG_DATA_BITS'(cfg_reg.stride);
            pced_pkg::REG_STRIDE_FRAC:
                prdata = pced_pkg::CFG_DATA_BITS'(cfg_reg.stride_frac);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= pced_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/pced_front.sv
// ----------------------------------------------------------------------------
// pced_front
// Point index tracking, sample selection and box classification.
// ----------------------------------------------------------------------------
module pced_front (
    input  logic             clk,
    input  logic             rst_n,
    input  pced_pkg::cfg_t   cfg,
    input  logic             in_valid,
    input  logic             in_last,
    input  pced_pkg::point_t in_point,
    input  logic             q_full,
    output logic             q_wr
);

    logic [pced_pkg::INDEX_BITS-1:0] point_index_reg;
    logic [pced_pkg::INDEX_BITS-1:0] point_index_next;
    logic [pced_pkg::NEXT_BITS-1:0]  next_sample_reg;
    logic [pced_pkg::NEXT_BITS-1:0]  next_sample_next;
    logic [pced_pkg::FRAC_BITS-1:0]  fraction_acc_reg;
    logic [pced_pkg::FRAC_BITS-1:0]  fraction_acc_next;

    logic                                    sampled;
    logic [2:0]                              outside;
    logic [2:0]                              in_ego;
    logic                                    keep;
    logic [pced_pkg::INDEX_BITS-1:0]         stride;
    logic [pced_pkg::FRAC_BITS:0]            frac_sum;
    logic [pced_pkg::NEXT_BITS:0]            nxt_sum;
    logic signed [pced_pkg::COORD_BITS-1:0]  p [3];
    logic signed [pced_pkg::COORD_BITS-1:0]  cl [3];
    logic signed [pced_pkg::COORD_BITS-1:0]  ch [3];
    logic signed [pced_pkg::COORD_BITS-1:0]  el [3];
    logic signed [pced_pkg::COORD_BITS-1:0]  eh [3];

    assign p[0] = in_point.x;
    assign p[1] = in_point.y;
    assign p[2] = in_point.z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cl[k] = $signed(cfg.crop_low[k*pced_pkg::COORD_BITS +: pced_pkg::COORD_BITS]);
            ch[k] = $signed(cfg.crop_high[k*pced_pkg::COORD_BITS +: pced_pkg::COORD_BITS]);
            el[k] = $signed(cfg.ego_low[k*pced_pkg::COORD_BITS +: pced_pkg::COORD_BITS]);
            eh[k] = $signed(cfg.ego_high[k*pced_pkg::COORD_BITS +: pced_pkg::COORD_BITS]);
            outside[k] = (p[k] < cl[k]) || (p[k] > ch[k]);
            in_ego[k]  = (p[k] > el[k]) && (p[k] < eh[k]);
        end
    end

    assign sampled = ({1'b0, point_index_reg} == next_sample_reg);
    assign keep    = sampled && !(|outside) && !(&in_ego);
    assign q_wr    = in_valid && keep;

    // zero stride behaves as one
    assign stride   = (cfg.stride == '0) ? pced_pkg::INDEX_BITS'(1) : cfg.stride;
    assign frac_sum = {1'b0, fraction_acc_reg} + {1'b0, cfg.stride_frac};
    assign nxt_sum  = {1'b0, next_sample_reg} + (pced_pkg::NEXT_BITS+1)'(stride)
                      + (pced_pkg::NEXT_BITS+1)'(keep && frac_sum[pced_pkg::FRAC_BITS]);

    always_comb
    begin
        point_index_next  = point_index_reg;
        next_sample_next  = next_sample_reg;
        fraction_acc_next = fraction_acc_reg;
        if (in_valid)
        begin
            if (sampled)
            begin
                next_sample_next = nxt_sum[pced_pkg::NEXT_BITS]
                                   ? '1 : nxt_sum[pced_pkg::NEXT_BITS-1:0];
                if (keep)
                begin
                    fraction_acc_next = frac_sum[pced_pkg::FRAC_BITS-1:0];
                end
            end
            if (in_last)
            begin
                point_index_next  = '0;
                next_sample_next  = '0;
                fraction_acc_next = '0;
            end
            else
            begin
                point_index_next = point_index_reg + pced_pkg::INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_index_reg  <= '0;
            next_sample_reg  <= '0;
            fraction_acc_reg <= '0;
        end
        else
        begin
            point_index_reg  <= point_index_next;
            next_sample_reg  <= next_sample_next;
            fraction_acc_reg <= fraction_acc_next;
        end
    end

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> !q_full)
        else $error("front writes into full queue");

    a_cloud_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_last |=> point_index_reg == '0 && next_sample_reg == '0
                                && fraction_acc_reg == '0)
        else $error("state not cleared after last point of cloud");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |=> $stable(point_index_reg) && $stable(next_sample_reg))
        else $error("index state moved without a request");

endmodule

FILE: hdl/pced_back.sv
// ----------------------------------------------------------------------------
// pced_back
// Result queue: holds kept points until the consumer takes them.
// ----------------------------------------------------------------------------
module pced_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  pced_pkg::point_t wr_point,
    input  logic             rd,
    output logic             full,
    output logic             empty,
    output pced_pkg::point_t head
);

    pced_pkg::point_t mem [pced_pkg::QUEUE_DEPTH];

    logic [pced_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [pced_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [pced_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [pced_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [pced_pkg::QUEUE_CNT_BITS-1:0] count_reg;
    logic [pced_pkg::QUEUE_CNT_BITS-1:0] count_next;
    logic                                do_wr;
    logic                                do_rd;

    assign full  = (count_reg == pced_pkg::QUEUE_CNT_BITS'(pced_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + pced_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + pced_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + pced_pkg::QUEUE_CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - pced_pkg::QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_point;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pced_pkg::QUEUE_CNT_BITS'(pced_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || full) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

    a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !rd |=> $stable(head))
        else $error("queue head changed without a pop");

endmodule

FILE: tb/point_crop_ego_decimate_core_tb.sv
// ----------------------------------------------------------------------------
// point_crop_ego_decimate_core_tb
// Self-checking bench for the crop-box / ego-box decimating point filter.
// Points go in through push/full, kept points are popped and compared
// field by field against a bit-accurate predictor of the filter that
// tracks the point index, the next sampled index and the stride fraction.
// Runs directed corner points, randomized configurations with random
// request gaps and pop stalls, a long pop hold-off that backs up the
// block, and clouds under the largest stride.
// ----------------------------------------------------------------------------
module point_crop_ego_decimate_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        pced_pkg::point_t pt;
        logic             last;
    } point_req_t;

    class kept_point_board;
        logic [pced_pkg::BOX_BITS-1:0]   crop_lo, crop_hi, ego_lo, ego_hi;
        logic [pced_pkg::INDEX_BITS-1:0] stride;
        logic [pced_pkg::FRAC_BITS-1:0]  frac;
        logic [pced_pkg::INDEX_BITS-1:0] pt_idx;
        logic [pced_pkg::NEXT_BITS-1:0]  sample_at;
        logic [pced_pkg::FRAC_BITS-1:0]  frac_sum;
        pced_pkg::point_t                kept_q[$];
        int                              errors;
        int                              checked;
        int                              accepted;

        function new();
            crop_lo = '0;
            crop_hi = '0;
            ego_lo = '0;
            ego_hi = '0;
            stride = pced_pkg::INDEX_BITS'(1);
            frac = '0;
            pt_idx = '0;
            sample_at = '0;
            frac_sum = '0;
            errors = 0;
            checked = 0;
            accepted = 0;
        endfunction

        function void set_reg(pced_pkg::reg_sel_t sel,
                              logic [pced_pkg::CFG_DATA_BITS-1:0] v);
            case (sel)
                pced_pkg::REG_CROP_LOW:    crop_lo = v[pced_pkg::BOX_BITS-1:0];
                pced_pkg::REG_CROP_HIGH:   crop_hi = v[pced_pkg::BOX_BITS-1:0];
                pced_pkg::REG_EGO_LOW:     ego_lo = v[pced_pkg::BOX_BITS-1:0];
                pced_pkg::REG_EGO_HIGH:    ego_hi = v[pced_pkg::BOX_BITS-1:0];
                pced_pkg::REG_STRIDE:      stride = v[pced_pkg::INDEX_BITS-1:0];
                pced_pkg::REG_STRIDE_FRAC: frac = v[pced_pkg::FRAC_BITS-1:0];
                default:                   ;
            endcase
        endfunction

        function logic signed [pced_pkg::COORD_BITS-1:0] axis(
            logic [pced_pkg::BOX_BITS-1:0] r, int k);
            return r[k*pced_pkg::COORD_BITS +: pced_pkg::COORD_BITS];
        endfunction

        function void accept_point(point_req_t r);
            logic signed [pced_pkg::COORD_BITS-1:0] p [3];
            logic [pced_pkg::INDEX_BITS-1:0] step;
            logic [pced_pkg::NEXT_BITS+1:0]  nxt;
            logic [pced_pkg::FRAC_BITS:0]    acc;
            bit outside;
            bit ego;
            bit keep;
            int k;
            outside = 0;
            ego = 1;
            keep = 0;
            accepted++;
            p[0] = r.pt.x;
            p[1] = r.pt.y;
            p[2] = r.pt.z;
            if ({1'b0, pt_idx} == sample_at)
            begin
                step = (stride == '0) ? pced_pkg::INDEX_BITS'(1) : stride;
                for (k = 0; k < 3; k++)
                begin
                    if (p[k] < axis(crop_lo, k) || p[k] > axis(crop_hi, k))
                        outside = 1;
                    if (!(p[k] > axis(ego_lo, k) && p[k] < axis(ego_hi, k)))
                        ego = 0;
                end
                keep = !outside && !ego;
                nxt = {2'b00, sample_at} + {3'b000, step};
                if (keep)
                begin
                    acc = {1'b0, frac_sum} + {1'b0, frac};
                    if (acc[pced_pkg::FRAC_BITS])
                        nxt = nxt + 1'b1;
                    frac_sum = acc[pced_pkg::FRAC_BITS-1:0];
                end
                sample_at = (nxt > {2'b00, {pced_pkg::NEXT_BITS{1'b1}}})
                            ? {pced_pkg::NEXT_BITS{1'b1}}
                            : nxt[pced_pkg::NEXT_BITS-1:0];
            end
            if (r.last)
            begin
                pt_idx = '0;
                sample_at = '0;
                frac_sum = '0;
            end
            else
            begin
                pt_idx = pt_idx + 1'b1;
            end
            if (keep)
                kept_q.insert(kept_q.size(), r.pt);
        endfunction

        function void cmp(string nm, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, nm, e, a);
                errors++;
            end
        endfunction

        function void check_kept(pced_pkg::point_t got);
            pced_pkg::point_t want;
            if (kept_q.size() == 0)
            begin
                $display("%0t: unexpected kept point, expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = kept_q.pop_front();
            checked++;
            cmp("out_x", want.x, got.x);
            cmp("out_y", want.y, got.y);
            cmp("out_z", want.z, got.z);
            cmp("out_intensity", want.intensity, got.intensity);
            cmp("out_ring", want.ring, got.ring);
            cmp("out_time", want.ptime, got.ptime);
        endfunction
    endclass

    logic                                    clk = 1'b0;
    logic                                    rst_n = 1'b0;
    logic                                    psel = 1'b0;
    logic                                    penable = 1'b0;
    logic                                    pwrite = 1'b0;
    logic [pced_pkg::CFG_ADDR_BITS-1:0]      paddr = '0;
    logic [pced_pkg::CFG_DATA_BITS-1:0]      pwdata = '0;
    logic [pced_pkg::CFG_DATA_BITS-1:0]      prdata;
    logic                                    pready;
    logic                                    push = 1'b0;
    logic                                    full;
    logic signed [pced_pkg::COORD_BITS-1:0]  pos_x = '0;
    logic signed [pced_pkg::COORD_BITS-1:0]  pos_y = '0;
    logic signed [pced_pkg::COORD_BITS-1:0]  pos_z = '0;
    logic [pced_pkg::INT_BITS-1:0]           intensity = '0;
    logic [pced_pkg::INT_BITS-1:0]           ring = '0;
    logic [pced_pkg::TIME_BITS-1:0]          pt_stamp = '0;
    logic                                    cloud_last = 1'b0;
    logic                                    empty;
    logic                                    pop = 1'b0;
    logic signed [pced_pkg::COORD_BITS-1:0]  out_x;
    logic signed [pced_pkg::COORD_BITS-1:0]  out_y;
    logic signed [pced_pkg::COORD_BITS-1:0]  out_z;
    logic [pced_pkg::INT_BITS-1:0]           out_intensity;
    logic [pced_pkg::INT_BITS-1:0]           out_ring;
    logic [pced_pkg::TIME_BITS-1:0]          out_time;

    kept_point_board sb = new();

    int  cycles = 0;
    bit  no_idle = 0;
    bit  hold_req = 0;
    int  crop_lo_v [3];
    int  crop_hi_v [3];
    int  ego_lo_v [3];
    int  ego_hi_v [3];

    point_crop_ego_decimate_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .intensity     (intensity),
        .ring          (ring),
        .pt_stamp      (pt_stamp),
        .cloud_last    (cloud_last),
        .empty         (empty),
        .pop           (pop),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .out_intensity (out_intensity),
        .out_ring      (out_ring),
        .out_time      (out_time)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: pops with random stall bursts and one long hold-off
    initial
    begin
        pced_pkg::point_t got;
        int               stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.x = out_x;
                got.y = out_y;
                got.z = out_z;
                got.intensity = out_intensity;
                got.ring = out_ring;
                got.ptime = out_time;
                sb.check_kept(got);
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                stall = 300;
                pop <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(0, 6);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic [pced_pkg::BOX_BITS-1:0] pack3(int a, int b, int c);
        return {16'(c), 16'(b), 16'(a)};
    endfunction

    function automatic point_req_t mk(int x, int y, int z, logic [7:0] inten,
                                      logic [7:0] rg, logic [31:0] t, bit last);
        point_req_t r;
        r.pt.x = 16'(x);
        r.pt.y = 16'(y);
        r.pt.z = 16'(z);
        r.pt.intensity = inten;
        r.pt.ring = rg;
        r.pt.ptime = t;
        r.last = last;
        return r;
    endfunction

    function automatic point_req_t rand_point();
        int v [3];
        int k;
        int lo;
        int hi;
        for (k = 0; k < 3; k++)
        begin
            lo = crop_lo_v[k];
            hi = crop_hi_v[k];
            case ($urandom_range(0, 5))
                0: v[k] = $urandom;
                1: v[k] = lo + int'($urandom_range(0, 4)) - 2;
                2: v[k] = hi + int'($urandom_range(0, 4)) - 2;
                3: v[k] = ego_lo_v[k] + int'($urandom_range(0, 4)) - 2;
                4: v[k] = ego_hi_v[k] + int'($urandom_range(0, 4)) - 2;
                default: v[k] = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo))
                                           : $urandom;
            endcase
        end
        return mk(v[0], v[1], v[2], 8'($urandom), 8'($urandom), $urandom,
                  $urandom_range(0, 24) == 0);
    endfunction

    task automatic send_point(input point_req_t r);
        push <= 1'b1;
        pos_x <= r.pt.x;
        pos_y <= r.pt.y;
        pos_z <= r.pt.z;
        intensity <= r.pt.intensity;
        ring <= r.pt.ring;
        pt_stamp <= r.pt.ptime;
        cloud_last <= r.last;
        do @(posedge clk); while (full);
        sb.accept_point(r);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic write_reg(input pced_pkg::reg_sel_t sel,
                             input logic [pced_pkg::CFG_DATA_BITS-1:0] val);
        logic [pced_pkg::CFG_DATA_BITS-1:0] mask;
        logic [pced_pkg::CFG_DATA_BITS-1:0] junk;
        case (sel)
            pced_pkg::REG_STRIDE:      mask = (64'd1 << pced_pkg::INDEX_BITS) - 64'd1;
            pced_pkg::REG_STRIDE_FRAC: mask = (64'd1 << pced_pkg::FRAC_BITS) - 64'd1;
            default:                   mask = (64'd1 << pced_pkg::BOX_BITS) - 64'd1;
        endcase
        junk = {$urandom, $urandom};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 3'b000};
        pwdata <= (val & mask) | (junk & ~mask);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(sel, val & mask);
    endtask

    // wait for every kept point to drain, then let the dropped ones pass as well
    task automatic settle();
        push <= 1'b0;
        while (sb.kept_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_cfg(input logic [19:0] strd, input logic [15:0] frc);
        write_reg(pced_pkg::REG_CROP_LOW, 64'(pack3(crop_lo_v[0], crop_lo_v[1],
                                                    crop_lo_v[2])));
        write_reg(pced_pkg::REG_CROP_HIGH, 64'(pack3(crop_hi_v[0], crop_hi_v[1],
                                                     crop_hi_v[2])));
        write_reg(pced_pkg::REG_EGO_LOW, 64'(pack3(ego_lo_v[0], ego_lo_v[1],
                                                   ego_lo_v[2])));
        write_reg(pced_pkg::REG_EGO_HIGH, 64'(pack3(ego_hi_v[0], ego_hi_v[1],
                                                    ego_hi_v[2])));
        write_reg(pced_pkg::REG_STRIDE, 64'(strd));
        write_reg(pced_pkg::REG_STRIDE_FRAC, 64'(frc));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_boxes(input int cl, input int ch, input int el, input int eh);
        int k;
        for (k = 0; k < 3; k++)
        begin
            crop_lo_v[k] = cl;
            crop_hi_v[k] = ch;
            ego_lo_v[k] = el;
            ego_hi_v[k] = eh;
        end
    endtask

    task automatic rand_cfg();
        int kind;
        int ek;
        int k;
        logic [19:0] strd;
        logic [15:0] frc;
        kind = $urandom_range(0, 9);
        ek = $urandom_range(0, 5);
        for (k = 0; k < 3; k++)
        begin
            if (kind == 0)
            begin
                crop_lo_v[k] = -32768;
                crop_hi_v[k] = 32767;
            end
            else if (kind == 1)
            begin
                crop_lo_v[k] = $urandom_range(0, 1000);
                crop_hi_v[k] = crop_lo_v[k] - int'($urandom_range(1, 1000));
            end
            else
            begin
                crop_lo_v[k] = int'($urandom_range(0, 4000)) - 2000;
                crop_hi_v[k] = crop_lo_v[k] + int'($urandom_range(0, 3000));
            end
            if (ek == 0)
            begin
                ego_lo_v[k] = 50;
                ego_hi_v[k] = -50;
            end
            else if (ek == 1)
            begin
                ego_lo_v[k] = 0;
                ego_hi_v[k] = 0;
            end
            else
            begin
                ego_lo_v[k] = -int'($urandom_range(0, 400));
                ego_hi_v[k] = $urandom_range(0, 400);
            end
        end
        case ($urandom_range(0, 9))
            0:       strd = '0;
            7:       strd = 20'($urandom_range(5, 40));
            8:       strd = 20'($urandom);
            9:       strd = 20'd1;
            default: strd = 20'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 3))
            0:       frc = '0;
            1:       frc = 16'hFFFF;
            default: frc = 16'($urandom);
        endcase
        load_cfg(strd, frc);
    endtask

    initial
    begin
        point_req_t r;
        int i;
        int ph;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: crop box and ego box both collapse to the origin
        set_boxes(0, 0, 0, 0);
        send_point(mk(0, 0, 0, 8'h00, 8'h00, 32'h0000_0000, 0));
        send_point(mk(1, 0, 0, 8'h11, 8'h22, 32'h1234_5678, 0));
        send_point(mk(-32768, -32768, -32768, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 0));
        send_point(mk(32767, 32767, 32767, 8'h5A, 8'hA5, 32'h8000_0001, 1));

        // full crop box, ego box edges are exclusive
        settle();
        set_boxes(-32768, 32767, -100, 100);
        load_cfg(20'd1, 16'd0);
        send_point(mk(-32768, -32768, -32768, 8'hFF, 8'h00, 32'hFFFF_FFFF, 0));
        send_point(mk(32767, 32767, 32767, 8'h00, 8'hFF, 32'h0000_0000, 0));
        send_point(mk(0, 0, 0, 8'h01, 8'h02, 32'h3, 0));
        send_point(mk(100, 0, 0, 8'h04, 8'h05, 32'h6, 0));
        send_point(mk(99, -99, 99, 8'h07, 8'h08, 32'h9, 0));
        send_point(mk(-100, 0, 0, 8'h0A, 8'h0B, 32'hC, 1));

        // narrow crop with inclusive edges, inverted ego box, zero stride
        settle();
        crop_lo_v = '{-10, -20, -30};
        crop_hi_v = '{10, 20, 30};
        ego_lo_v = '{100, 100, 100};
        ego_hi_v = '{-100, -100, -100};
        load_cfg(20'd0, 16'd0);
        send_point(mk(-10, -20, -30, 8'h10, 8'h20, 32'hA5A5_A5A5, 0));
        send_point(mk(10, 20, 30, 8'h30, 8'h40, 32'h5A5A_5A5A, 0));
        send_point(mk(11, 0, 0, 8'h50, 8'h60, 32'h1, 0));
        send_point(mk(0, -21, 0, 8'h70, 8'h80, 32'h2, 0));
        send_point(mk(0, 0, 31, 8'h90, 8'hA0, 32'h3, 0));
        send_point(mk(0, 0, 0, 8'hB0, 8'hC0, 32'h4, 1));

        // inverted crop box keeps nothing
        settle();
        set_boxes(10, -10, 0, 0);
        load_cfg(20'd1, 16'd0);
        send_point(mk(0, 0, 0, 8'h01, 8'h01, 32'h1, 0));
        send_point(mk(10, -10, 5, 8'h02, 8'h02, 32'h2, 1));

        // stride 3 with half fraction: every second kept point skips one more
        settle();
        set_boxes(-32768, 32767, 100, -100);
        load_cfg(20'd3, 16'h8000);
        for (i = 0; i < 11; i++)
            send_point(mk(i, -i, i * 7, 8'(i), 8'(255 - i), 32'(i * 1000), i == 9));

        // random configurations; the second phase holds off pops to fill the queue
        for (ph = 0; ph < 6; ph++)
        begin
            settle();
            if (ph == 1)
            begin
                set_boxes(-32768, 32767, 0, 0);
                load_cfg(20'd1, 16'd0);
                hold_req = 1;
            end
            else
            begin
                rand_cfg();
            end
            if (ph == 5)
                no_idle = 1;
            for (i = 0; i < 140; i++)
                send_point(rand_point());
        end

        // largest stride: only the first point of each cloud is sampled
        settle();
        set_boxes(-32768, 32767, 0, 0);
        load_cfg(20'hFFFFF, 16'hFFFF);
        for (i = 0; i < 20; i++)
        begin
            r = rand_point();
            r.last = (i == 9);
            send_point(r);
        end

        push <= 1'b0;
        while (sb.kept_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Pushed %0d points, checked %0d kept points", sb.accepted, sb.checked);
        $display("Covered corner boxes, strides and fractions, and a full-queue backup");
        if (sb.errors == 0 && sb.kept_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
